>>> hw/rtl/pwmf_pkg.sv
// Shared types and constants for the frequency/duty PWM timer.
// Holds register indexes, field widths, reset values and the
// command/status structs between the controller and the datapath.
`default_nettype none

package pwmf_pkg;

  localparam int unsigned CLOCK_HZ_DEFAULT     = 64000000;
  localparam int unsigned COUNTER_SPAN_DEFAULT = 65536;

  localparam int unsigned FREQ_W     = 26;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned CFG_DATA_W = FREQ_W;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY = 1'b1;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 26'd1000;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
  localparam int unsigned       PERCENT    = 100;

  typedef enum logic [1:0] {
    STEP_FREQ = 2'd0,
    STEP_PRE  = 2'd1,
    STEP_PER  = 2'd2,
    STEP_CMP  = 2'd3
  } pwmf_step_t;

  typedef struct packed {
    logic       start;
    pwmf_step_t step;
    logic       busy;
  } pwmf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cfg_write;
  } pwmf_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/pwm_timer_from_freq_duty.sv
// Top level of the PWM timer set up by frequency and duty percent.
// Joins pwmf_ctrl and pwmf_datapath; depends on pwmf_pkg.
//
//   channel | signals                                   | moves
//   --------+-------------------------------------------+-----------------------------
//   in      | in_valid, in_ready, tick_enable           | one timer tick per transaction
//   out     | out_valid, out_ready, pwm_level, period_end | one result per input
//   cfg     | cfg_write_en, cfg_index, cfg_data         | register write, no wait
//
// One transaction per cycle while the limits are settled and the output is not stalled;
// the counters are registered and update when a transaction is accepted. After reset and
// after every register write the limits are rebuilt in four steps: a bit-serial division
// for the frequency, a prescale shift, a bit-serial division for the period and a
// reciprocal multiply for the compare value, during which in_ready stays low. The result
// register lets a new transaction in while the previous result is taken in the same cycle;
// a stalled output holds in_ready low.
`default_nettype none

module pwm_timer_from_freq_duty
  import pwmf_pkg::*;
#(
  parameter int unsigned CLOCK_HZ     = CLOCK_HZ_DEFAULT,
  parameter int unsigned COUNTER_SPAN = COUNTER_SPAN_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  tick_enable,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       pwm_level,
  output logic                       period_end
);

  pwmf_cmd_t    cmd;
  pwmf_status_t status;

  pwmf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  pwmf_datapath #(
    .CLOCK_HZ     (CLOCK_HZ),
    .COUNTER_SPAN (COUNTER_SPAN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tick_enable  (tick_enable),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pwm_level    (pwm_level),
    .period_end   (period_end)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pwmf_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; no package dependency.
`default_nettype none

module pwmf_div #(
  parameter int unsigned W = 26
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] numer,
  input  wire logic [W-1:0] denom,
  output logic [W-1:0]      quotient,
  output logic              done
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     den;
  logic [CNT_W-1:0] cnt;
  logic             running;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_next;

  assign trial    = {rem, quo[W-1]};
  assign diff     = trial - {1'b0, den};
  assign fits     = trial >= {1'b0, den};
  assign rem_next = fits ? diff[W-1:0] : trial[W-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= '0;
        quo     <= numer;
        den     <= denom;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem <= rem_next;
        quo <= {quo[W-2:0], fits};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pwmf_datapath.sv
// Datapath: configuration registers, timer limits, shared divider,
// prescale and period counters, and the result register.
// Depends on pwmf_pkg and pwmf_div.
`default_nettype none

module pwmf_datapath
  import pwmf_pkg::*;
#(
  parameter int unsigned CLOCK_HZ     = CLOCK_HZ_DEFAULT,
  parameter int unsigned COUNTER_SPAN = COUNTER_SPAN_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pwmf_cmd_t             cmd,
  output pwmf_status_t               status,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  tick_enable,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       pwm_level,
  output logic                       period_end
);

  localparam int unsigned PER_W   = $clog2(COUNTER_SPAN);
  localparam int unsigned CLK_W   = $clog2(CLOCK_HZ + 1);
  localparam int unsigned PROD_W  = PER_W + DUTY_W;
  localparam int unsigned DIV_W   = CLK_W;
  localparam int unsigned PRE_MAX = CLOCK_HZ / COUNTER_SPAN;
  localparam int unsigned PRE_W   = (PRE_MAX < 1) ? 1 : $clog2(PRE_MAX + 1);
  localparam int unsigned FCMP_W  = (FREQ_W > DIV_W) ? FREQ_W : DIV_W;

  // round-up reciprocal of 100 scaled by 2^30, exact for products below 2^23
  localparam int unsigned       RECIP_SHIFT = 30;
  localparam int unsigned       RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_100  = 24'd10737419;
  localparam int unsigned       SCALE_W     = PROD_W + RECIP_W;

  logic [FREQ_W-1:0] freq_hz;
  logic [DUTY_W-1:0] duty_percent;

  logic [DIV_W-1:0] division;
  logic [PRE_W-1:0] prescale_limit;
  logic [PER_W-1:0] period;
  logic [PER_W-1:0] reload_value;
  logic [PER_W-1:0] compare_value;
  logic [PRE_W-1:0] prescale_count;
  logic [PER_W-1:0] period_count;

  logic [FCMP_W-1:0] freq_ext;
  logic [DIV_W-1:0]  freq_sat;
  logic [DUTY_W-1:0] duty_sat;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] product_q;
  logic [SCALE_W-1:0] scaled;
  logic [DIV_W-1:0]  numer;
  logic [DIV_W-1:0]  denom;
  logic [DIV_W-1:0]  quotient;
  logic              div_start;
  logic              div_done;
  logic              cmp_pend;
  logic              fast_done;
  logic [PER_W-1:0]  period_q;

  logic             accept;
  logic             pre_wrap;
  logic             per_wrap;
  logic [PRE_W-1:0] prescale_count_next;
  logic [PER_W-1:0] period_count_next;
  logic             wrapped;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_hz      <= FREQ_RESET;
      duty_percent <= DUTY_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_FREQ) begin
        freq_hz <= cfg_data[FREQ_W-1:0];
      end
      if (cfg_index == REG_DUTY) begin
        duty_percent <= cfg_data[DUTY_W-1:0];
      end
    end
  end

  assign status.cfg_write = cfg_write_en && (cfg_index == REG_FREQ || cfg_index == REG_DUTY);
  assign status.div_done  = div_done || fast_done;

  // Saturate the register values into range
  assign freq_ext = FCMP_W'(freq_hz);
  always_comb begin
    if (freq_ext == '0) begin
      freq_sat = DIV_W'(1);
    end else if (freq_ext > FCMP_W'(CLOCK_HZ)) begin
      freq_sat = DIV_W'(CLOCK_HZ);
    end else begin
      freq_sat = freq_ext[DIV_W-1:0];
    end
  end

  assign duty_sat = (duty_percent > DUTY_MAX) ? DUTY_MAX : duty_percent;
  assign product  = PROD_W'(period) * PROD_W'(duty_sat);
  assign scaled   = SCALE_W'(product_q) * SCALE_W'(RECIP_100);

  always_comb begin
    unique case (cmd.step)
      STEP_FREQ: begin
        numer = DIV_W'(CLOCK_HZ);
        denom = freq_sat;
      end
      STEP_PER: begin
        numer = division;
        denom = DIV_W'(prescale_limit) + DIV_W'(1);
      end
      default: begin
        numer = '0;
        denom = DIV_W'(1);
      end
    endcase
  end

  assign div_start = cmd.start && (cmd.step == STEP_FREQ || cmd.step == STEP_PER);

  pwmf_div #(
    .W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (denom),
    .quotient (quotient),
    .done     (div_done)
  );

  assign period_q = (quotient == '0) ? PER_W'(1) : quotient[PER_W-1:0];

  // Capture each quotient into its limit register
  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.step)
        STEP_FREQ: division <= quotient;
        STEP_PER: begin
          period       <= period_q;
          reload_value <= period_q - PER_W'(1);
        end
        default:   division <= division;
      endcase
    end
  end

  // Prescale by shift, compare by reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend  <= 1'b0;
      fast_done <= 1'b0;
    end else if (status.cfg_write) begin
      cmp_pend  <= 1'b0;
      fast_done <= 1'b0;
    end else begin
      cmp_pend  <= cmd.start && (cmd.step == STEP_CMP);
      fast_done <= cmp_pend || (cmd.start && (cmd.step == STEP_PRE));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && (cmd.step == STEP_PRE)) begin
      prescale_limit <= PRE_W'(division >> PER_W);
    end
    if (cmd.start && (cmd.step == STEP_CMP)) begin
      product_q <= product;
    end
    if (cmp_pend) begin
      compare_value <= scaled[RECIP_SHIFT +: PER_W];
    end
  end

  // Counters and result register
  assign in_ready = !cmd.busy && !cfg_write_en && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign pre_wrap = prescale_count >= prescale_limit;
  assign per_wrap = period_count >= reload_value;

  always_comb begin
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    wrapped             = 1'b0;
    if (tick_enable) begin
      if (pre_wrap) begin
        prescale_count_next = '0;
        if (per_wrap) begin
          period_count_next = '0;
          wrapped           = 1'b1;
        end else begin
          period_count_next = period_count + PER_W'(1);
        end
      end else begin
        prescale_count_next = prescale_count + PRE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      period_count   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        prescale_count <= prescale_count_next;
        period_count   <= period_count_next;
        pwm_level      <= period_count_next < compare_value;
        period_end     <= wrapped;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pwmf_ctrl.sv
// Controller: sequences the four steps (two divisions, a shift, a multiply) that
// turn frequency and duty into prescale, reload and compare limits. Depends on pwmf_pkg.
`default_nettype none

module pwmf_ctrl
  import pwmf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire pwmf_status_t status,
  output pwmf_cmd_t         cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_FREQ_GO   = 9'b000000010,
    S_FREQ_WAIT = 9'b000000100,
    S_PRE_GO    = 9'b000001000,
    S_PRE_WAIT  = 9'b000010000,
    S_PER_GO    = 9'b000100000,
    S_PER_WAIT  = 9'b001000000,
    S_CMP_GO    = 9'b010000000,
    S_CMP_WAIT  = 9'b100000000
  } pwmf_state_t;

  pwmf_state_t state;
  pwmf_state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      state_next = state;
      S_FREQ_GO:   state_next = S_FREQ_WAIT;
      S_FREQ_WAIT: if (status.div_done) state_next = S_PRE_GO;
      S_PRE_GO:    state_next = S_PRE_WAIT;
      S_PRE_WAIT:  if (status.div_done) state_next = S_PER_GO;
      S_PER_GO:    state_next = S_PER_WAIT;
      S_PER_WAIT:  if (status.div_done) state_next = S_CMP_GO;
      S_CMP_GO:    state_next = S_CMP_WAIT;
      S_CMP_WAIT:  if (status.div_done) state_next = S_IDLE;
      default:     state_next = S_FREQ_GO;
    endcase
    // restart the whole sequence on any register write
    if (status.cfg_write) begin
      state_next = S_FREQ_GO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FREQ_GO;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.busy  = 1'b1;
    cmd.step  = STEP_FREQ;
    unique case (state)
      S_IDLE:      cmd.busy = 1'b0;
      S_FREQ_GO:   cmd.start = 1'b1;
      S_FREQ_WAIT: cmd.step = STEP_FREQ;
      S_PRE_GO: begin
        cmd.start = 1'b1;
        cmd.step  = STEP_PRE;
      end
      S_PRE_WAIT:  cmd.step = STEP_PRE;
      S_PER_GO: begin
        cmd.start = 1'b1;
        cmd.step  = STEP_PER;
      end
      S_PER_WAIT:  cmd.step = STEP_PER;
      S_CMP_GO: begin
        cmd.start = 1'b1;
        cmd.step  = STEP_CMP;
      end
      S_CMP_WAIT:  cmd.step = STEP_CMP;
      default:     cmd.busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire
